// ----- src/radix2_complex_fft_unit_assert.svh -----
// Assertion macros for the FFT unit.
`ifndef RADIX2_COMPLEX_FFT_UNIT_ASSERT_SVH
`define RADIX2_COMPLEX_FFT_UNIT_ASSERT_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define FFT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fft assertion failed");

// Check that an antecedent implies a consequent in the next cycle.
`define FFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fft assertion failed");

`endif

// ----- src/fft_pkg.sv -----
`timescale 1ns / 1ps
package fft_pkg;

    localparam int DataBits = 24;

    typedef struct packed {
        logic signed [15:0] sample_real;
        logic signed [15:0] sample_imag;
    } t_in_word;

    typedef struct packed {
        logic signed [23:0] result_real;
        logic signed [23:0] result_imag;
        logic               last_result;
    } t_out_word;

    localparam logic [1:0] ModeBypass  = 2'd0;
    localparam logic [1:0] ModeForward = 2'd1;
    localparam logic [1:0] ModeInvScl  = 2'd2;
    localparam logic [1:0] ModeInvRaw  = 2'd3;

    // Quarter-wave cosine, round(32767*cos(2*pi*k/64)), k = 0..16.
    function automatic logic signed [16:0] quarter_cos(input logic [4:0] k);
        logic signed [16:0] v;
        case (k)
            5'd0:  v = 17'sd32767;
            5'd1:  v = 17'sd32609;
            5'd2:  v = 17'sd32137;
            5'd3:  v = 17'sd31356;
            5'd4:  v = 17'sd30273;
            5'd5:  v = 17'sd28898;
            5'd6:  v = 17'sd27245;
            5'd7:  v = 17'sd25329;
            5'd8:  v = 17'sd23170;
            5'd9:  v = 17'sd20787;
            5'd10: v = 17'sd18204;
            5'd11: v = 17'sd15446;
            5'd12: v = 17'sd12539;
            5'd13: v = 17'sd9512;
            5'd14: v = 17'sd6393;
            5'd15: v = 17'sd3212;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [16:0] cos_rom(input logic [4:0] k);
        logic signed [16:0] v;
        if (k <= 5'd16) v = quarter_cos(k);
        else v = -quarter_cos(5'(6'd32 - {1'b0, k}));
        return v;
    endfunction

    function automatic logic signed [16:0] sin_rom(input logic [4:0] k);
        logic signed [16:0] v;
        if (k <= 5'd16) v = quarter_cos(5'(5'd16 - k));
        else v = quarter_cos(5'(k - 5'd16));
        return v;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
        logic signed [23:0] r;
        if (v > 27'sd8388607) r = 24'sh7FFFFF;
        else if (v < -27'sd8388608) r = 24'sh800000;
        else r = v[23:0];
        return r;
    endfunction

endpackage

// ----- src/fft_ram.sv -----
`timescale 1ns / 1ps
module fft_ram #(
    parameter int Width = 48,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/fft_bfly.sv -----
`timescale 1ns / 1ps
// Pipelined butterfly: the products are registered, then sums, rounding and saturation are combinational.
module fft_bfly (
    input  logic               i_clk,
    input  logic signed [23:0] i_ar,
    input  logic signed [23:0] i_ai,
    input  logic signed [23:0] i_br,
    input  logic signed [23:0] i_bi,
    input  logic signed [16:0] i_wr,
    input  logic signed [16:0] i_wi,
    output logic [47:0]        o_top,
    output logic [47:0]        o_bot
);
    logic signed [40:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [23:0] r_ar, r_ai;
    logic signed [42:0] s_tr, s_ti;
    logic signed [26:0] s_trn, s_tin;

    always_ff @(posedge i_clk) begin
        r_p0 <= i_wr * i_br;
        r_p1 <= i_wi * i_bi;
        r_p2 <= i_wr * i_bi;
        r_p3 <= i_wi * i_br;
        r_ar <= i_ar;
        r_ai <= i_ai;
    end

    always_comb begin
        s_tr  = 43'(r_p0) - 43'(r_p1) + 43'sd16384;
        s_ti  = 43'(r_p2) + 43'(r_p3) + 43'sd16384;
        s_trn = 27'(s_tr >>> 15);
        s_tin = 27'(s_ti >>> 15);
        o_top = {fft_pkg::sat24(27'(r_ai) + s_tin), fft_pkg::sat24(27'(r_ar) + s_trn)};
        o_bot = {fft_pkg::sat24(27'(r_ai) - s_tin), fft_pkg::sat24(27'(r_ar) - s_trn)};
    end
endmodule

// ----- src/radix2_complex_fft_unit.sv -----
`timescale 1ns / 1ps
// Channel  | Signals                               | Payload
// input    | i_in_valid / o_in_ready / i_in_word   | fft_pkg::t_in_word
// output   | o_out_valid / i_out_ready / o_out_word| fft_pkg::t_out_word
// config   | i_cfg_we / i_cfg_data                 | transform_mode, 2 bits
//
// Load takes one word per cycle; after the last word of a frame the block
// runs (POINTS/2)*log2(POINTS) butterflies (none in bypass mode), each stepping
// through the one memory port pair (read a, read b, multiply, write a, write b),
// then emits POINTS words, each read from memory and then registered to the
// output, and holds while the sink stalls. Input is held off from the end of
// load until the last word is taken. Reset is synchronous, active low, and
// clears control only; the sample memory is not cleared.
module radix2_complex_fft_unit #(
    parameter int POINTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  fft_pkg::t_in_word    i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output fft_pkg::t_out_word   o_out_word,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_data
);
    `include "radix2_complex_fft_unit_assert.svh"

    localparam int Lg = $clog2(POINTS);
    localparam int Ab = (Lg < 1) ? 1 : Lg;
    localparam int Sb = (Lg < 2) ? 1 : $clog2(Lg);

    typedef enum logic [3:0] {
        ST_LOAD = 4'b0001,
        ST_BFLY = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_mode, r_fmode;
    logic [Ab-1:0] r_cnt;          // load position / emit index
    logic [Sb-1:0] r_stage;        // butterfly stage (log2 of l1)
    logic [Ab-1:0] r_bidx;         // butterfly index within stage
    logic [1:0] r_ph;              // butterfly phase
    logic [Ab-1:0] r_ia, r_ib;
    logic       r_rdv;             // read issued last cycle (emit)
    logic       r_ovalid;
    fft_pkg::t_out_word r_oword;
    logic [47:0] r_aword;

    logic        s_we;
    logic [Ab-1:0] s_waddr, s_raddr;
    logic [47:0] s_wdata, s_rdata, s_top, s_bot;

    // Bit reversal over Lg bits.
    function automatic logic [Ab-1:0] brev(input logic [Ab-1:0] v);
        logic [Ab-1:0] r;
        r = v;
        for (int b = 0; b < Lg; b++) r[b] = v[Lg-1-b];
        return r;
    endfunction

    // Butterfly addressing: l1 = 1<<stage, j = low bits, group = high bits.
    logic [Ab-1:0] s_l1, s_jmask, s_i0, s_i1, s_j;
    logic [4:0]    s_k;
    logic signed [16:0] s_wr, s_wi;
    always_comb begin
        s_l1    = Ab'(1) << r_stage;
        s_jmask = s_l1 - Ab'(1);
        s_j     = r_bidx & s_jmask;
        s_i0    = ((r_bidx & ~s_jmask) << 1) | s_j;
        s_i1    = s_i0 | s_l1;
        s_k     = 5'(6'(s_j) << (5 - r_stage));
        s_wr    = fft_pkg::cos_rom(s_k);
        s_wi    = (r_fmode == fft_pkg::ModeForward) ? -fft_pkg::sin_rom(s_k)
                                                    : fft_pkg::sin_rom(s_k);
    end

    fft_ram #(.Width(48), .Depth(1 << Ab)) u_ram (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    // b word arrives with phase 2 read data; a word was captured in phase 1.
    fft_bfly u_bfly (
        .i_clk(i_clk),
        .i_ar(r_aword[23:0]), .i_ai(r_aword[47:24]),
        .i_br(s_rdata[23:0]), .i_bi(s_rdata[47:24]),
        .i_wr(s_wr), .i_wi(s_wi), .o_top(s_top), .o_bot(s_bot)
    );

    logic s_in_acc, s_out_take, s_slot, s_last_bfly, s_emit_load;
    assign o_in_ready  = (r_state == ST_LOAD);
    assign s_in_acc    = i_in_valid && o_in_ready;
    assign s_out_take  = r_ovalid && i_out_ready;
    assign s_slot      = !r_ovalid || i_out_ready;
    assign s_last_bfly = (r_bidx == Ab'(POINTS/2 - 1)) && (r_stage == Sb'(Lg - 1));
    assign s_emit_load = (r_state == ST_EMIT) && r_rdv && s_slot;

    // Memory port steering.
    logic signed [23:0] s_vr, s_vi;
    always_comb begin
        s_we = 1'b0;
        s_waddr = brev(r_cnt);
        s_wdata = {24'(i_in_word.sample_imag), 24'(i_in_word.sample_real)};
        s_raddr = r_cnt;
        unique case (r_state)
            ST_LOAD: s_we = s_in_acc;
            ST_BFLY: begin
                s_raddr = (r_ph == 2'd0) ? s_i0 : s_i1;
                s_we    = (r_ph == 2'd2) || (r_ph == 2'd3);
                // write the top word in phase 2, the bottom word in phase 3
                s_waddr = (r_ph == 2'd2) ? r_ia : r_ib;
                s_wdata = (r_ph == 2'd2) ? s_top : s_bot;
            end
            ST_DRAIN: s_raddr = r_cnt;
            ST_EMIT: s_raddr = (r_fmode == fft_pkg::ModeBypass) ? brev(r_cnt) : r_cnt;
            default: ;
        endcase
        s_vr = s_rdata[23:0];
        s_vi = s_rdata[47:24];
        if (r_fmode == fft_pkg::ModeInvScl) begin
            s_vr = s_vr >>> Lg;
            s_vi = s_vi >>> Lg;
        end
    end

    // Butterfly timing: bph0 read a, bph1 read b and capture a, bph2 multiply,
    // bph3 sums valid and write top, bph4 write bottom from the same sums.
    logic [2:0] r_bph;
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD:  if (s_in_acc && r_cnt == Ab'(POINTS - 1))
                          n_state = (r_mode == fft_pkg::ModeBypass) ? ST_EMIT : ST_BFLY;
            ST_BFLY:  if (r_bph == 3'd4 && s_last_bfly) n_state = ST_EMIT;
            ST_DRAIN: n_state = ST_EMIT;
            ST_EMIT:  if (s_out_take && r_oword.last_result) n_state = ST_LOAD;
            default:  n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_mode   <= fft_pkg::ModeForward;
            r_fmode  <= fft_pkg::ModeForward;
            r_cnt    <= '0;
            r_stage  <= '0;
            r_bidx   <= '0;
            r_bph    <= '0;
            r_rdv    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_mode <= i_cfg_data;
            if (s_emit_load) r_ovalid <= 1'b1;
            else if (s_out_take) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_LOAD: if (s_in_acc) begin
                    // sample the mode with the last word of the frame
                    if (r_cnt == Ab'(POINTS - 1)) begin
                        r_cnt <= '0;
                        r_fmode <= r_mode;
                        r_stage <= '0;
                        r_bidx <= '0;
                        r_bph <= '0;
                        r_rdv <= 1'b0;
                    end else r_cnt <= r_cnt + Ab'(1);
                end
                ST_BFLY: begin
                    // bph: 0 read a, 1 read b/capture a, 2 mult, 3 sums valid,
                    // 4 write bottom (top written in 3)
                    if (r_bph == 3'd4) begin
                        r_bph <= '0;
                        if (r_bidx == Ab'(POINTS/2 - 1)) begin
                            r_bidx <= '0;
                            r_stage <= r_stage + Sb'(1);
                        end else r_bidx <= r_bidx + Ab'(1);
                    end else r_bph <= r_bph + 3'd1;
                    if (r_bph == 3'd0) begin
                        r_ia <= s_i0;
                        r_ib <= s_i1;
                    end
                end
                ST_EMIT: begin
                    if (r_rdv && s_slot) begin
                        r_oword.result_real <= s_vr;
                        r_oword.result_imag <= s_vi;
                        r_oword.last_result <= (r_cnt == Ab'(POINTS - 1));
                        r_rdv <= 1'b0;
                        if (r_cnt == Ab'(POINTS - 1)) r_cnt <= '0;
                        else r_cnt <= r_cnt + Ab'(1);
                    end else if (!r_rdv && !(r_ovalid && r_oword.last_result)) begin
                        r_rdv <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Phase decode of the 5-phase butterfly for the memory and a-capture.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_BFLY && r_bph == 3'd1) r_aword <= s_rdata;
    end
    assign r_ph = (r_bph == 3'd0) ? 2'd0 :
                  (r_bph == 3'd1) ? 2'd1 :
                  (r_bph == 3'd3) ? 2'd2 :
                  (r_bph == 3'd4) ? 2'd3 : 2'd1;

    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_oword;

    `FFT_ASSERT_IMPL(a_no_in_busy, i_clk, i_rst_n, r_state != ST_LOAD, !o_in_ready)
    `FFT_ASSERT_IMPL(a_out_only_emit, i_clk, i_rst_n, r_ovalid, r_state == ST_EMIT)
    `FFT_ASSERT_NEXT(a_last_to_load, i_clk, i_rst_n, s_out_take && r_oword.last_result, r_state == ST_LOAD)
endmodule
